// ===== rtl/sihist_pkg.sv =====
package sihist_pkg;

   // Request item codes carried on req_tuser.
   localparam logic [1:0] MODE_HIT   = 2'd0;
   localparam logic [1:0] MODE_READ  = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;
   localparam logic [1:0] MODE_NOP   = 2'd3;

   // Configuration register indexes.
   localparam logic CSR_WIN_BEFORE = 1'b0;
   localparam logic CSR_WIN_AFTER  = 1'b1;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 304;
   localparam int BIN_IDX_W   = 7;
   localparam int DIFF_W      = 30;
   localparam int CSR_W       = 16;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW    = 3;
   localparam int FIFO_CNT_W = 4;

   // Smallest interval d with 10*log10(d) >= k + 1, for k = 0 .. NUM_THRESH-1.
   localparam int NUM_THRESH = 90;
   localparam logic [DIFF_W-1:0] THRESH_TAB [NUM_THRESH] = '{
      30'd2,         30'd2,         30'd2,         30'd3,         30'd4,
      30'd4,         30'd6,         30'd7,         30'd8,         30'd10,
      30'd13,        30'd16,        30'd20,        30'd26,        30'd32,
      30'd40,        30'd51,        30'd64,        30'd80,        30'd100,
      30'd126,       30'd159,       30'd200,       30'd252,       30'd317,
      30'd399,       30'd502,       30'd631,       30'd795,       30'd1000,
      30'd1259,      30'd1585,      30'd1996,      30'd2512,      30'd3163,
      30'd3982,      30'd5012,      30'd6310,      30'd7944,      30'd10000,
      30'd12590,     30'd15849,     30'd19953,     30'd25119,     30'd31623,
      30'd39811,     30'd50119,     30'd63096,     30'd79433,     30'd100000,
      30'd125893,    30'd158490,    30'd199527,    30'd251189,    30'd316228,
      30'd398108,    30'd501188,    30'd630958,    30'd794329,    30'd1000000,
      30'd1258926,   30'd1584894,   30'd1995263,   30'd2511887,   30'd3162278,
      30'd3981072,   30'd5011873,   30'd6309574,   30'd7943283,   30'd10000000,
      30'd12589255,  30'd15848932,  30'd19952624,  30'd25118865,  30'd31622777,
      30'd39810718,  30'd50118724,  30'd63095735,  30'd79432824,  30'd100000000,
      30'd125892542, 30'd158489320, 30'd199526232, 30'd251188644, 30'd316227767,
      30'd398107171, 30'd501187234, 30'd630957345, 30'd794328235, 30'd1000000000
   };

   // One result item; the last field sits in the lowest bits.
   typedef struct packed {
      logic [31:0] lost_total;
      logic [31:0] hit_total;
      logic [63:0] bin_sum;
      logic [31:0] bin_count;
      logic [63:0] previous_time;
      logic        previous_good;
      logic        lost_seen;
      logic        anomalous;
      logic        bin_valid;
      logic [6:0]  diff_bin;
      logic [63:0] extended_time;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

   // One histogram bin as held in memory.
   typedef struct packed {
      logic [63:0] sum;
      logic [31:0] count;
   } hist_entry_type;

   typedef struct packed {
      logic [1:0]           mode;
      logic [63:0]          ext;
      logic [63:0]          prev;
      logic [63:0]          prev2;
      logic                 lost;
      logic                 anom;
      logic                 upd;
      logic [DIFF_W-1:0]    diff;
      logic [BIN_IDX_W-1:0] idx;
      logic [31:0]          hit_total;
      logic [31:0]          lost_total;
   } stage1_type;

   typedef struct packed {
      logic [1:0]            mode;
      logic [63:0]           ext;
      logic [63:0]           prev_time;
      logic                  good;
      logic                  lost;
      logic                  anom;
      logic                  upd;
      logic [DIFF_W-1:0]     diff;
      logic [BIN_IDX_W-1:0]  idx;
      logic [31:0]           hit_total;
      logic [31:0]           lost_total;
      logic [NUM_THRESH-1:0] ge;
   } stage2_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [63:0]        ext;
      logic [63:0]        prev_time;
      logic               good;
      logic               lost;
      logic               anom;
      logic               upd;
      logic [DIFF_W-1:0]  diff;
      logic               in_range;
      logic [31:0]        hit_total;
      logic [31:0]        lost_total;
   } stage3_type;

   function automatic logic [31:0] sat_inc32(input logic [31:0] v);
      return (v == 32'hffff_ffff) ? v : v + 32'd1;
   endfunction

endpackage

// ===== rtl/stamp_interval_log_histogram_top.sv =====
// Hit-interval log histogram.
// Request channel (req_*): each item carries a mode on req_tuser and a stamp word plus a
// bin index on req_tdata. A hit item extends the 31-bit time to 64 bits, bins the
// interval to the previous hit into one of LAST_BIN+1 log bins, ten per decade, and
// judges the previous hit for pile-up; a read item returns one bin; a clear item
// empties the histogram and the hit and lost counters but keeps the time history.
// Result channel (rsp_*): exactly one item per request item, in request order.
// Configuration port (csr_*): the two pile-up windows, written while the block is idle.
// A result is offered on rsp_tvalid once its item has passed the pipeline into the queue.
// Throughput: one item per cycle while req_tready is high. The bin memory is read in
// stage 2 and written back in stage 3, with a one-entry forward for back-to-back hits to the
// same bin, so consecutive hits never wait on each other.
// Results collect in an eight-entry output queue; req_tready stays high as long as the
// queue plus the items still in the pipeline leave room, so a stalled receiver only
// stops the request side once that room is used up.
// Reset clears the time history, the counters and the per-bin valid flags;
// there is no clearing pass over the memory, and the block is ready right away.
module stamp_interval_log_histogram_top #(
   parameter int LAST_BIN = 70
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // stamp_word [31:0], bin_index [38:32], zero [39]
   input  logic [sihist_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // mode [1:0]
   input  logic [1:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // extended_time [63:0], diff_bin [70:64], bin_valid [71], anomalous [72],
   // lost_seen [73], previous_good [74], previous_time [138:75], bin_count [170:139],
   // bin_sum [234:171], hit_total [266:235], lost_total [298:267], zero [303:299]
   output logic [sihist_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [sihist_pkg::CSR_W-1:0]        csr_wdata
);

   localparam int BIN_DEPTH = LAST_BIN + 1;
   localparam int BIN_AW    = $clog2(BIN_DEPTH);
   localparam int IDX_W     = sihist_pkg::BIN_IDX_W;
   localparam int HIST_W    = $bits(sihist_pkg::hist_entry_type);
   localparam int PAD_W     = sihist_pkg::RSP_TDATA_W - sihist_pkg::RESULT_W;
   localparam int CNT_W     = sihist_pkg::FIFO_CNT_W;

   // Configuration registers.
   logic [sihist_pkg::CSR_W-1:0] win_before_ff;
   logic [sihist_pkg::CSR_W-1:0] win_after_ff;

   // Time history and counters.
   logic [30:0] last_low_ff,   last_low_in;
   logic [32:0] wrap_cnt_ff,   wrap_cnt_in;
   logic        have_prev_ff,  have_prev_in;
   logic [30:0] prev_low_ff,   prev_low_in;
   logic [63:0] time_prev_ff,  time_prev_in;
   logic [63:0] time_prev2_ff, time_prev2_in;
   logic [31:0] hit_cnt_ff,    hit_cnt_in;
   logic [31:0] lost_cnt_ff,   lost_cnt_in;

   // Pipeline.
   logic                   v1_ff, v2_ff, v3_ff;
   sihist_pkg::stage1_type s1_ff, s1_in;
   sihist_pkg::stage2_type s2_ff, s2_in;
   sihist_pkg::stage3_type s3_ff, s3_in;
   logic [BIN_AW-1:0]      addr3_ff, addr3_in;

   // Bin memory side.
   logic [BIN_DEPTH-1:0]       valid_ff, valid_in;
   logic                       fwd_ff, fwd_in;
   sihist_pkg::hist_entry_type fwd_data_ff;
   sihist_pkg::hist_entry_type cur_entry, new_entry, ram_rdata;
   logic [HIST_W-1:0]          ram_rdata_raw;
   logic                       ram_wr_en;
   logic [BIN_AW-1:0]          rd_addr2;
   logic [BIN_AW-1:0]          bin2;

   // Output queue.
   sihist_pkg::result_type       fifo_ff [sihist_pkg::FIFO_DEPTH];
   sihist_pkg::result_type       result3;
   logic [sihist_pkg::FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]               fifo_cnt_ff, fifo_cnt_in;
   logic [CNT_W-1:0]               in_flight;
   logic                           fifo_push, fifo_pop;

   logic        accept;
   logic [1:0]  req_mode;
   logic [30:0] value;
   logic        lost_bit;
   logic        is_hit;
   logic [30:0] diff_full;
   logic        wrap_step;
   logic [32:0] wrap_next;

   // ---------------------------------------------------------------------------
   // Request side: the whole time history moves at the accepting edge so that the
   // next item can follow in the next cycle.
   // ---------------------------------------------------------------------------
   assign req_mode  = req_tuser;
   assign value     = req_tdata[30:0];
   assign lost_bit  = req_tdata[31];
   assign is_hit    = (req_mode == sihist_pkg::MODE_HIT);
   assign diff_full = value - prev_low_ff;
   assign wrap_step = (value < last_low_ff);
   assign wrap_next = wrap_cnt_ff + 33'(wrap_step);

   assign in_flight = CNT_W'(v1_ff) + CNT_W'(v2_ff) + CNT_W'(v3_ff);
   assign req_tready = ((in_flight + fifo_cnt_ff) < CNT_W'(sihist_pkg::FIFO_DEPTH));
   assign accept = req_tvalid && req_tready;

   always_comb begin
      last_low_in   = last_low_ff;
      wrap_cnt_in   = wrap_cnt_ff;
      have_prev_in  = have_prev_ff;
      prev_low_in   = prev_low_ff;
      time_prev_in  = time_prev_ff;
      time_prev2_in = time_prev2_ff;
      hit_cnt_in    = hit_cnt_ff;
      lost_cnt_in   = lost_cnt_ff;
      if (accept) begin
         unique case (req_mode)
            sihist_pkg::MODE_HIT: begin
               last_low_in   = value;
               wrap_cnt_in   = wrap_next;
               have_prev_in  = 1'b1;
               prev_low_in   = value;
               time_prev2_in = time_prev_ff;
               // The wrap offset is always a multiple of 2^31, so the sum is a join.
               time_prev_in  = {wrap_next, value};
               hit_cnt_in    = sihist_pkg::sat_inc32(hit_cnt_ff);
               if (have_prev_ff && lost_bit) begin
                  lost_cnt_in = sihist_pkg::sat_inc32(lost_cnt_ff);
               end
            end
            sihist_pkg::MODE_CLEAR: begin
               hit_cnt_in  = '0;
               lost_cnt_in = '0;
            end
            sihist_pkg::MODE_READ: begin
            end
            sihist_pkg::MODE_NOP: begin
            end
         endcase
      end
   end

   always_comb begin
      s1_in.mode       = req_mode;
      s1_in.ext        = {wrap_next, value};
      s1_in.prev       = time_prev_ff;
      s1_in.prev2      = time_prev2_ff;
      s1_in.lost       = is_hit && lost_bit;
      s1_in.anom       = is_hit && have_prev_ff && !lost_bit && diff_full[30];
      s1_in.upd        = is_hit && have_prev_ff && !lost_bit && !diff_full[30];
      s1_in.diff       = diff_full[sihist_pkg::DIFF_W-1:0];
      s1_in.idx        = req_tdata[38:32];
      s1_in.hit_total  = hit_cnt_in;
      s1_in.lost_total = lost_cnt_in;
   end

   // ---------------------------------------------------------------------------
   // Stage 1: compare the interval against the threshold table and judge pile-up.
   // ---------------------------------------------------------------------------
   logic        prev_none, prev2_none, ok_before, ok_after;
   logic [63:0] d_before, d_after;

   assign prev_none  = (s1_ff.prev == '1);
   assign prev2_none = (s1_ff.prev2 == '1);
   assign d_before   = s1_ff.prev - s1_ff.prev2;
   assign d_after    = s1_ff.ext - s1_ff.prev;
   assign ok_before  = prev2_none || (d_before > 64'(win_before_ff));
   assign ok_after   = (d_after > 64'(win_after_ff));

   always_comb begin
      s2_in.mode       = s1_ff.mode;
      s2_in.ext        = s1_ff.ext;
      s2_in.lost       = s1_ff.lost;
      s2_in.anom       = s1_ff.anom;
      s2_in.upd        = s1_ff.upd;
      s2_in.diff       = s1_ff.diff;
      s2_in.idx        = s1_ff.idx;
      s2_in.hit_total  = s1_ff.hit_total;
      s2_in.lost_total = s1_ff.lost_total;
      if ((s1_ff.mode == sihist_pkg::MODE_HIT) && !prev_none) begin
         s2_in.good      = ok_before && ok_after;
         s2_in.prev_time = s1_ff.prev;
      end else begin
         s2_in.good      = 1'b0;
         s2_in.prev_time = '0;
      end
      for (int k = 0; k < sihist_pkg::NUM_THRESH; k++) begin
         s2_in.ge[k] = (k < LAST_BIN) && (s1_ff.diff >= sihist_pkg::THRESH_TAB[k]);
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: the bin is the first threshold not reached; issue the memory read.
   // ---------------------------------------------------------------------------
   always_comb begin
      bin2 = BIN_AW'(LAST_BIN);
      for (int k = LAST_BIN - 1; k >= 0; k--) begin
         if (!s2_ff.ge[k]) begin
            bin2 = BIN_AW'(k);
         end
      end
   end

   always_comb begin
      s3_in.mode       = s2_ff.mode;
      s3_in.ext        = s2_ff.ext;
      s3_in.prev_time  = s2_ff.prev_time;
      s3_in.good       = s2_ff.good;
      s3_in.lost       = s2_ff.lost;
      s3_in.anom       = s2_ff.anom;
      s3_in.upd        = s2_ff.upd;
      s3_in.diff       = s2_ff.diff;
      s3_in.hit_total  = s2_ff.hit_total;
      s3_in.lost_total = s2_ff.lost_total;
      s3_in.in_range   = (s2_ff.idx <= IDX_W'(LAST_BIN));
      if (s2_ff.mode == sihist_pkg::MODE_READ) begin
         rd_addr2 = s3_in.in_range ? BIN_AW'(s2_ff.idx) : '0;
      end else begin
         rd_addr2 = bin2;
      end
      addr3_in = rd_addr2;
   end

   sihist_ram #(
      .WIDTH (HIST_W),
      .DEPTH (BIN_DEPTH)
   ) u_bin_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr3_ff),
      .wr_data (new_entry),
      .rd_en   (v2_ff),
      .rd_addr (rd_addr2),
      .rd_data (ram_rdata_raw)
   );

   assign ram_rdata = ram_rdata_raw;

   // ---------------------------------------------------------------------------
   // Stage 3: modify and write back. A bin that has not been written since the last
   // clear reads as empty; a write from the item just ahead is forwarded.
   // ---------------------------------------------------------------------------
   logic [64:0] sum_wide;

   always_comb begin
      priority if (fwd_ff) begin
         cur_entry = fwd_data_ff;
      end else if (valid_ff[addr3_ff]) begin
         cur_entry = ram_rdata;
      end else begin
         cur_entry = '0;
      end
   end

   assign sum_wide = {1'b0, cur_entry.sum} + 65'(s3_ff.diff);
   assign new_entry.count = sihist_pkg::sat_inc32(cur_entry.count);
   assign new_entry.sum   = sum_wide[64] ? '1 : sum_wide[63:0];
   assign ram_wr_en = v3_ff && s3_ff.upd;
   assign fwd_in    = ram_wr_en && v2_ff && (rd_addr2 == addr3_ff);

   always_comb begin
      valid_in = valid_ff;
      if (v3_ff && (s3_ff.mode == sihist_pkg::MODE_CLEAR)) begin
         valid_in = '0;
      end else if (ram_wr_en) begin
         valid_in[addr3_ff] = 1'b1;
      end
   end

   always_comb begin
      result3.extended_time = (s3_ff.mode == sihist_pkg::MODE_HIT) ? s3_ff.ext : '0;
      result3.diff_bin      = s3_ff.upd ? IDX_W'(addr3_ff) : '0;
      result3.bin_valid     = s3_ff.upd;
      result3.anomalous     = s3_ff.anom;
      result3.lost_seen     = s3_ff.lost;
      result3.previous_good = s3_ff.good;
      result3.previous_time = s3_ff.prev_time;
      if ((s3_ff.mode == sihist_pkg::MODE_READ) && s3_ff.in_range) begin
         result3.bin_count = cur_entry.count;
         result3.bin_sum   = cur_entry.sum;
      end else begin
         result3.bin_count = '0;
         result3.bin_sum   = '0;
      end
      result3.hit_total  = s3_ff.hit_total;
      result3.lost_total = s3_ff.lost_total;
   end

   // ---------------------------------------------------------------------------
   // Output queue.
   // ---------------------------------------------------------------------------
   assign fifo_push   = v3_ff;
   assign fifo_pop    = rsp_tvalid && rsp_tready;
   assign fifo_cnt_in = fifo_cnt_ff + CNT_W'(fifo_push) - CNT_W'(fifo_pop);
   assign rsp_tvalid  = (fifo_cnt_ff != '0);
   assign rsp_tdata   = {{PAD_W{1'b0}}, fifo_ff[rd_ptr_ff]};

   // ---------------------------------------------------------------------------
   // Registers.
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         win_before_ff <= sihist_pkg::CSR_W'(10);
         win_after_ff  <= sihist_pkg::CSR_W'(10);
         last_low_ff   <= '0;
         wrap_cnt_ff   <= '0;
         have_prev_ff  <= 1'b0;
         prev_low_ff   <= '0;
         time_prev_ff  <= '1;
         time_prev2_ff <= '1;
         hit_cnt_ff    <= '0;
         lost_cnt_ff   <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         valid_ff      <= '0;
         fwd_ff        <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_cnt_ff   <= '0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               sihist_pkg::CSR_WIN_BEFORE: win_before_ff <= csr_wdata;
               sihist_pkg::CSR_WIN_AFTER:  win_after_ff  <= csr_wdata;
            endcase
         end
         last_low_ff   <= last_low_in;
         wrap_cnt_ff   <= wrap_cnt_in;
         have_prev_ff  <= have_prev_in;
         prev_low_ff   <= prev_low_in;
         time_prev_ff  <= time_prev_in;
         time_prev2_ff <= time_prev2_in;
         hit_cnt_ff    <= hit_cnt_in;
         lost_cnt_ff   <= lost_cnt_in;
         v1_ff         <= accept;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
         valid_ff      <= valid_in;
         fwd_ff        <= fwd_in;
         fifo_cnt_ff   <= fifo_cnt_in;
         if (fifo_push) begin
            wr_ptr_ff <= wr_ptr_ff + sihist_pkg::FIFO_AW'(1);
         end
         if (fifo_pop) begin
            rd_ptr_ff <= rd_ptr_ff + sihist_pkg::FIFO_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_ff       <= s1_in;
      s2_ff       <= s2_in;
      s3_ff       <= s3_in;
      addr3_ff    <= addr3_in;
      fwd_data_ff <= new_entry;
      if (fifo_push) begin
         fifo_ff[wr_ptr_ff] <= result3;
      end
   end

   // ---------------------------------------------------------------------------
   // Assertions.
   // ---------------------------------------------------------------------------
   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (fifo_cnt_ff < CNT_W'(sihist_pkg::FIFO_DEPTH)))
      else $error("result pushed into a full output queue");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      (in_flight + fifo_cnt_ff) <= CNT_W'(sihist_pkg::FIFO_DEPTH))
      else $error("items in flight exceed output queue room");

   a_clear_empties_bins: assert property (@(posedge clock) disable iff (reset)
      (v3_ff && (s3_ff.mode == sihist_pkg::MODE_CLEAR)) |=> (valid_ff == '0))
      else $error("bins still marked valid after a clear");

   a_hit_count_saturates: assert property (@(posedge clock) disable iff (reset)
      ((hit_cnt_ff == '1) && !(accept && (req_mode == sihist_pkg::MODE_CLEAR)))
      |=> (hit_cnt_ff == '1))
      else $error("hit counter left saturation without a clear");

   a_forward_same_bin: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> (v3_ff && ($past(addr3_ff) == addr3_ff)))
      else $error("forwarded bin data does not match the bin being updated");

endmodule

// ===== rtl/sihist_ram.sv =====
module sihist_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 71,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when the same entry is written at the same edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
